// ----- design/lne_pkg.sv -----
package lne_pkg;

	localparam int BUFFER_DEPTH_DEF = 128;

	localparam logic [7:0] KEY_ESCAPE    = 8'd27;
	localparam logic [7:0] KEY_BACKSPACE = 8'd8;
	localparam logic [7:0] KEY_PREFIX    = 8'd224;
	localparam logic [7:0] EXT_LEFT      = 8'd75;
	localparam logic [7:0] EXT_RIGHT     = 8'd77;
	localparam logic [7:0] EXT_DELETE    = 8'd83;
	localparam logic [7:0] EXT_INSERT    = 8'd82;

	typedef struct packed {
		logic       action;
		logic       extended;
		logic [7:0] key_code;
		logic [6:0] read_index;
	} cmd_word_t;

	typedef struct packed {
		logic [6:0] cursor_pos;
		logic [6:0] line_length;
		logic       insert_on;
		logic [7:0] char_out;
		logic       stopped;
	} res_word_t;

endpackage

// ----- design/lne_line_mem.sv -----
module lne_line_mem #(
	parameter int DEPTH = lne_pkg::BUFFER_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/keystroke_line_editor.sv -----
// channel   direction  handshake                  payload
// command   in         start high, busy low       cmd    (lne_pkg::cmd_word_t)
// result    out        done high for one cycle    result (lne_pkg::res_word_t)
//
// a read or a cursor/mode/escape key goes from accept straight to ST_RESP, which registers result and done
// insert, delete and backspace move the tail of the line through the single
// memory port pair, one character per cycle, before ST_FINAL writes the key or zeroes the freed slot
// reset sets insert mode and clears cursor, length and stop; bytes past the line read as zero
// busy stays high until the result strobe; the receiver cannot stall done
module keystroke_line_editor #(
	parameter int BUFFER_DEPTH = lne_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lne_pkg::cmd_word_t  cmd,
	output logic                done,
	output lne_pkg::res_word_t  result
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = (AW > 7) ? AW : 7;
	localparam logic [AW-1:0] FULL_MARK = AW'(BUFFER_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE,
		ST_FINAL,
		ST_RESP
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      cur_q;
	logic [AW-1:0]      fill_q;
	logic               ins_q;
	logic               halt_q;
	logic [AW-1:0]      src_q;
	logic [AW-1:0]      cnt_q;
	logic               up_q;
	logic               wr_key_q;
	logic               bs_q;
	logic [7:0]         key_q;
	logic               rd_q;
	logic               rd_hit_q;
	logic               wvalid_s1;
	logic [AW-1:0]      wdst_s1;
	logic               done_q;
	lne_pkg::res_word_t res_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	lne_line_mem #(
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign mem_raddr = (state_q == ST_IDLE) ? AW'(cmd.read_index) : src_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = src_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_MOVE: begin
				mem_we    = wvalid_s1;
				mem_waddr = wdst_s1;
				mem_wdata = mem_rdata;
			end
			ST_FINAL: begin
				mem_we    = 1'b1;
				mem_waddr = wr_key_q ? cur_q : fill_q - 1'b1;
				mem_wdata = wr_key_q ? key_q : 8'd0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			fill_q    <= '0;
			ins_q     <= 1'b1;
			halt_q    <= 1'b0;
			src_q     <= '0;
			cnt_q     <= '0;
			up_q      <= 1'b0;
			wr_key_q  <= 1'b0;
			bs_q      <= 1'b0;
			key_q     <= '0;
			rd_hit_q  <= 1'b0;
			wvalid_s1 <= 1'b0;
			wdst_s1   <= '0;
			done_q    <= 1'b0;
			rd_q      <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						wvalid_s1 <= 1'b0;
						key_q     <= cmd.key_code;
						rd_q      <= cmd.action;
						rd_hit_q  <= CW'(cmd.read_index) < CW'(fill_q);
						state_q   <= ST_RESP;
						if (!cmd.action && !halt_q) begin
							if (cmd.extended) begin
								priority if (cmd.key_code == lne_pkg::EXT_LEFT && cur_q != '0) begin
									cur_q <= cur_q - 1'b1;
								end else if (cmd.key_code == lne_pkg::EXT_RIGHT &&
									cur_q < fill_q) begin
									cur_q <= cur_q + 1'b1;
								end else if (cmd.key_code == lne_pkg::EXT_DELETE) begin
									if (cur_q < fill_q) begin
										src_q    <= cur_q + 1'b1;
										cnt_q    <= fill_q - cur_q - 1'b1;
										up_q     <= 1'b0;
										wr_key_q <= 1'b0;
										bs_q     <= 1'b0;
										state_q  <= ST_MOVE;
									end
								end else if (cmd.key_code == lne_pkg::EXT_INSERT) begin
									ins_q <= ~ins_q;
								end else begin
									ins_q <= ins_q;
								end
							end else begin
								priority if (cmd.key_code == lne_pkg::KEY_ESCAPE) begin
									halt_q <= 1'b1;
								end else if (cmd.key_code == lne_pkg::KEY_BACKSPACE) begin
									if (cur_q != '0) begin
										src_q    <= cur_q;
										cnt_q    <= fill_q - cur_q;
										up_q     <= 1'b0;
										wr_key_q <= 1'b0;
										bs_q     <= 1'b1;
										state_q  <= ST_MOVE;
									end
								end else if (cmd.key_code == lne_pkg::KEY_PREFIX) begin
									halt_q <= halt_q;
								end else if (fill_q < FULL_MARK) begin
									src_q    <= fill_q - 1'b1;
									cnt_q    <= ins_q ? fill_q - cur_q : '0;
									up_q     <= 1'b1;
									wr_key_q <= 1'b1;
									bs_q     <= 1'b0;
									state_q  <= ST_MOVE;
								end else begin
									halt_q <= halt_q;
								end
							end
						end
					end
				end
				ST_MOVE: begin
					if (cnt_q != '0) begin
						wvalid_s1 <= 1'b1;
						wdst_s1   <= up_q ? src_q + 1'b1 : src_q - 1'b1;
						src_q     <= up_q ? src_q - 1'b1 : src_q + 1'b1;
						cnt_q     <= cnt_q - 1'b1;
					end else begin
						wvalid_s1 <= 1'b0;
						if (!wvalid_s1) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					if (wr_key_q) begin
						cur_q <= cur_q + 1'b1;
						if (ins_q || cur_q == fill_q) begin
							fill_q <= fill_q + 1'b1;
						end
					end else begin
						fill_q <= fill_q - 1'b1;
						if (bs_q) begin
							cur_q <= cur_q - 1'b1;
						end
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					res_q.cursor_pos  <= 7'(cur_q);
					res_q.line_length <= 7'(fill_q);
					res_q.insert_on   <= ins_q;
					res_q.char_out    <= (rd_q && rd_hit_q) ? mem_rdata : 8'd0;
					res_q.stopped     <= halt_q;
					done_q            <= 1'b1;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- sim/line_editor_checker.sv -----
module line_editor_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  lne_pkg::cmd_word_t cmd,
	input  logic               done,
	input  lne_pkg::res_word_t result,
	output int                 fault_count,
	output int                 awaited_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = lne_pkg::BUFFER_DEPTH_DEF;

	logic [7:0]         line_mem [DEPTH];
	int                 cur;
	int                 fill;
	bit                 ins;
	bit                 halt;
	lne_pkg::res_word_t awaited_results [$];

	function automatic void clear_line();
		for (int i = 0; i < DEPTH; i++)
			line_mem[i] = '0;
		cur = 0;
		fill = 0;
		ins = 1'b1;
		halt = 1'b0;
	endfunction

	// close the gap at pos and zero the slot freed at the old line end
	function automatic void drop_char(input int pos);
		for (int i = pos; i + 1 < fill; i++)
			line_mem[i] = line_mem[i + 1];
		fill--;
		line_mem[fill] = '0;
	endfunction

	function automatic lne_pkg::res_word_t edit_line(input lne_pkg::cmd_word_t c);
		lne_pkg::res_word_t r;
		r = '0;
		if (c.action) begin
			if (int'(c.read_index) < DEPTH)
				r.char_out = line_mem[c.read_index];
		end else if (!halt) begin
			if (c.extended) begin
				case (c.key_code)
					lne_pkg::EXT_LEFT: if (cur > 0) cur--;
					lne_pkg::EXT_RIGHT: if (cur < fill) cur++;
					lne_pkg::EXT_DELETE: if (cur < fill) drop_char(cur);
					lne_pkg::EXT_INSERT: ins = !ins;
					default: ;
				endcase
			end else begin
				case (c.key_code)
					lne_pkg::KEY_ESCAPE: halt = 1'b1;
					lne_pkg::KEY_BACKSPACE: if (cur > 0) begin
						drop_char(cur - 1);
						cur--;
					end
					lne_pkg::KEY_PREFIX: ;
					default: if (fill < DEPTH - 1) begin
						if (ins) begin
							for (int i = fill; i > cur; i--)
								line_mem[i] = line_mem[i - 1];
							line_mem[cur] = c.key_code;
							fill++;
						end else begin
							line_mem[cur] = c.key_code;
							if (cur >= fill)
								fill++;
						end
						cur++;
					end
				endcase
			end
		end
		r.cursor_pos = 7'(cur);
		r.line_length = 7'(fill);
		r.insert_on = ins;
		r.stopped = halt;
		return r;
	endfunction

	task automatic report_fault(input string msg);
		$display("%0t ns: %s", $time, msg);
		fault_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_fault($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		lne_pkg::res_word_t want;
		if (!arst_n) begin
			clear_line();
			awaited_results.delete();
			fault_count = 0;
			awaited_count = 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_fault("result word with no command waiting");
				end else begin
					want = awaited_results.pop_front();
					check_field("cursor_pos", result.cursor_pos, want.cursor_pos);
					check_field("line_length", result.line_length, want.line_length);
					check_field("insert_on", result.insert_on, want.insert_on);
					check_field("char_out", result.char_out, want.char_out);
					check_field("stopped", result.stopped, want.stopped);
				end
			end
			if (start && !busy)
				awaited_results.push_back(edit_line(cmd));
			awaited_count = awaited_results.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_COUNT     = 1300;
	localparam int PHASE_LEN      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 200;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               done;
	lne_pkg::cmd_word_t cmd;
	lne_pkg::res_word_t result;
	int                 fault_count;
	int                 awaited_count;
	int                 idle_cycles;

	keystroke_line_editor i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	line_editor_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.done          (done),
		.result        (result),
		.fault_count   (fault_count),
		.awaited_count (awaited_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic lne_pkg::cmd_word_t key_word(input bit ext, input logic [7:0] key);
		lne_pkg::cmd_word_t c;
		c.action = 1'b0;
		c.extended = ext;
		c.key_code = key;
		c.read_index = 7'($urandom);
		return c;
	endfunction

	function automatic lne_pkg::cmd_word_t read_word(input logic [6:0] idx);
		lne_pkg::cmd_word_t c;
		c.action = 1'b1;
		c.extended = 1'($urandom);
		c.key_code = 8'($urandom);
		c.read_index = idx;
		return c;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(4, 1);
		return $urandom_range(200, 10);
	endfunction

	// grow phases mostly type, shrink phases mostly erase
	function automatic lne_pkg::cmd_word_t random_word(input bit grow);
		int         roll;
		logic [7:0] ch;
		ch = 8'($urandom);
		if (ch == lne_pkg::KEY_ESCAPE)
			ch = lne_pkg::KEY_PREFIX;
		if ($urandom_range(99) < 15)
			return read_word(7'($urandom));
		roll = $urandom_range(99);
		if (roll < (grow ? 70 : 15))
			return key_word(1'b0, ch);
		if (roll < (grow ? 78 : 50))
			return key_word(1'b0, lne_pkg::KEY_BACKSPACE);
		if (roll < (grow ? 82 : 65))
			return key_word(1'b1, lne_pkg::EXT_DELETE);
		if (roll < (grow ? 90 : 78))
			return key_word(1'b1, lne_pkg::EXT_LEFT);
		if (roll < (grow ? 95 : 92))
			return key_word(1'b1, lne_pkg::EXT_RIGHT);
		if (roll < (grow ? 97 : 95))
			return key_word(1'b1, lne_pkg::EXT_INSERT);
		return key_word(1'b1, 8'($urandom));
	endfunction

	task automatic send_word(input lne_pkg::cmd_word_t c, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("keystroke_line_editor test failed");
				$finish;
			end
		end
	end

	initial begin
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// edges of an empty line
		send_word(read_word(7'd0), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_LEFT), pick_gap());
		send_word(key_word(1'b0, lne_pkg::KEY_BACKSPACE), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_DELETE), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_RIGHT), pick_gap());
		// extreme bytes, bare prefix, unknown extended codes
		send_word(key_word(1'b0, 8'h00), pick_gap());
		send_word(key_word(1'b0, 8'hff), pick_gap());
		send_word(key_word(1'b0, lne_pkg::KEY_PREFIX), pick_gap());
		send_word(key_word(1'b1, lne_pkg::KEY_ESCAPE), pick_gap());
		send_word(key_word(1'b1, lne_pkg::KEY_BACKSPACE), pick_gap());
		send_word(key_word(1'b1, 8'hff), pick_gap());
		// insert mid line, then overwrite mid line and at the end
		send_word(key_word(1'b1, lne_pkg::EXT_LEFT), pick_gap());
		send_word(key_word(1'b0, 8'h41), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_INSERT), pick_gap());
		send_word(key_word(1'b0, 8'h42), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_RIGHT), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_RIGHT), pick_gap());
		send_word(key_word(1'b0, 8'h43), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_INSERT), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_LEFT), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_LEFT), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_DELETE), pick_gap());
		send_word(key_word(1'b0, lne_pkg::KEY_BACKSPACE), pick_gap());
		send_word(read_word(7'd1), pick_gap());
		send_word(read_word(7'd127), pick_gap());

		for (int n = 0; n < ITEM_COUNT; n++)
			send_word(random_word((n / PHASE_LEN) % 2 == 0),
				(n % 100 < 20) ? 0 : pick_gap());

		// stopped editor: keys ignored, reads still served
		send_word(key_word(1'b0, lne_pkg::KEY_ESCAPE), pick_gap());
		send_word(key_word(1'b0, 8'h5a), pick_gap());
		send_word(key_word(1'b0, lne_pkg::KEY_BACKSPACE), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_INSERT), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_LEFT), pick_gap());
		send_word(key_word(1'b1, lne_pkg::EXT_DELETE), pick_gap());
		for (int n = 0; n < 12; n++)
			send_word(random_word(1'b1), pick_gap());

		@(negedge clk);
		start <= 1'b0;
		wait (awaited_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("keystroke_line_editor test passed");
		else
			$display("keystroke_line_editor test failed");
		$finish;
	end

endmodule
